@@ src/cywp_pkg.sv @@
// Shared types and constants for the cascaded yaw / wheel PID controller.
// Used by the register block, the top level and the port checker.
package cywp_pkg;

  // Operation codes of a request
  localparam logic [1:0] FUNC_SPEED = 2'd0;
  localparam logic [1:0] FUNC_TURN  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HEADING_MODE = 3'd0;
  localparam logic [2:0] REG_HEADING_KP   = 3'd1;
  localparam logic [2:0] REG_HEADING_KI   = 3'd2;
  localparam logic [2:0] REG_HEADING_KD   = 3'd3;
  localparam logic [2:0] REG_WHEEL_MODE   = 3'd4;
  localparam logic [2:0] REG_WHEEL_KP     = 3'd5;
  localparam logic [2:0] REG_WHEEL_KI     = 3'd6;
  localparam logic [2:0] REG_WHEEL_KD     = 3'd7;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int GAIN_W = 16;
  localparam int DUTY_W = 15;

  // Datapath widths
  localparam int NPID  = 3;
  localparam int W40   = 40;           // stored error / sum / output
  localparam int D_W   = 41;           // first differences
  localparam int OP_W  = 43;           // multiplier operand
  localparam int T_W   = 42;           // wheel / heading target
  localparam int LO_W  = 22;           // low operand chunk, unsigned
  localparam int HI_W  = OP_W - LO_W;  // high operand chunk, signed
  localparam int MB_W  = LO_W + 1;
  localparam int PP_W  = GAIN_W + MB_W;
  localparam int ACC_W = 64;

  localparam logic signed [ACC_W-1:0] S40_MAX = (64'sd1 <<< (W40 - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] S40_MIN = -(64'sd1 <<< (W40 - 1));

  typedef struct packed {
    logic                     heading_mode;
    logic signed [GAIN_W-1:0] heading_kp;
    logic signed [GAIN_W-1:0] heading_ki;
    logic signed [GAIN_W-1:0] heading_kd;
    logic                     wheel_mode;
    logic signed [GAIN_W-1:0] wheel_kp;
    logic signed [GAIN_W-1:0] wheel_ki;
    logic signed [GAIN_W-1:0] wheel_kd;
  } cfg_t;

endpackage

@@ src/cywp_regs.sv @@
// APB-style configuration registers: modes and Q8.8 gains of the PIDs.
// Depends on cywp_pkg for register indexes and the cfg_t bundle.
module cywp_regs
  import cywp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_HEADING_MODE: cfg_r.heading_mode <= pwdata[0];
        REG_HEADING_KP:   cfg_r.heading_kp   <= pwdata[GAIN_W-1:0];
        REG_HEADING_KI:   cfg_r.heading_ki   <= pwdata[GAIN_W-1:0];
        REG_HEADING_KD:   cfg_r.heading_kd   <= pwdata[GAIN_W-1:0];
        REG_WHEEL_MODE:   cfg_r.wheel_mode   <= pwdata[0];
        REG_WHEEL_KP:     cfg_r.wheel_kp     <= pwdata[GAIN_W-1:0];
        REG_WHEEL_KI:     cfg_r.wheel_ki     <= pwdata[GAIN_W-1:0];
        REG_WHEEL_KD:     cfg_r.wheel_kd     <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADING_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_r.heading_mode};
      REG_HEADING_KP:   prdata = {{(DATA_W-GAIN_W){cfg_r.heading_kp[GAIN_W-1]}},
                                  cfg_r.heading_kp};
      REG_HEADING_KI:   prdata = {{(DATA_W-GAIN_W){cfg_r.heading_ki[GAIN_W-1]}},
                                  cfg_r.heading_ki};
      REG_HEADING_KD:   prdata = {{(DATA_W-GAIN_W){cfg_r.heading_kd[GAIN_W-1]}},
                                  cfg_r.heading_kd};
      REG_WHEEL_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.wheel_mode};
      REG_WHEEL_KP:     prdata = {{(DATA_W-GAIN_W){cfg_r.wheel_kp[GAIN_W-1]}},
                                  cfg_r.wheel_kp};
      REG_WHEEL_KI:     prdata = {{(DATA_W-GAIN_W){cfg_r.wheel_ki[GAIN_W-1]}},
                                  cfg_r.wheel_ki};
      REG_WHEEL_KD:     prdata = {{(DATA_W-GAIN_W){cfg_r.wheel_kd[GAIN_W-1]}},
                                  cfg_r.wheel_kd};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ src/cascaded_yaw_wheel_pid.sv @@
// Cascaded yaw / wheel PID drive controller; uses cywp_pkg and cywp_regs.
// Turn requests run three PIDs (heading, left, right), speed requests two,
// clear or an unused code none; each PID takes 15 steps of one sequencer
// around a single 16x23 multiplier and a 64-bit adder. in_ready rises with
// out_valid: one request at a time; a stalled result holds back the next one.
// Synchronous active-low reset clears control state, gains and PID history.
module cascaded_yaw_wheel_pid
  import cywp_pkg::*;
#(
  parameter int DUTY_MAX  = 9999,
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic signed [15:0]       in_base_speed,
  input  logic signed [9:0]        in_target_yaw,
  input  logic signed [9:0]        in_measured_yaw,
  input  logic signed [15:0]       in_left_count,
  input  logic signed [15:0]       in_right_count,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DUTY_W-1:0] out_left_duty,
  output logic signed [DUTY_W-1:0] out_right_duty,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [ADDR_W-1:0]        cfg_paddr,
  input  logic [DATA_W-1:0]        cfg_pwdata,
  output logic [DATA_W-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic signed [ACC_W-1:0] LIM     = ACC_W'(DUTY_MAX) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] NEG_LIM = -LIM;
  localparam logic signed [W40-1:0]   RND     = W40'((1 << FRAC_BITS) - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TGT  = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_DIF1 = 4'd3;
  localparam logic [3:0] ST_DIF2 = 4'd4;
  localparam logic [3:0] ST_MLO  = 4'd5;
  localparam logic [3:0] ST_MHI  = 4'd6;
  localparam logic [3:0] ST_MADD = 4'd7;
  localparam logic [3:0] ST_SATI = 4'd8;
  localparam logic [3:0] ST_SATO = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  localparam logic [1:0] MUL_KI = 2'd0;
  localparam logic [1:0] MUL_KP = 2'd1;
  localparam logic [1:0] MUL_KD = 2'd2;

  localparam logic [1:0] PID_HEAD  = 2'd0;
  localparam logic [1:0] PID_LEFT  = 2'd1;
  localparam logic [1:0] PID_RIGHT = 2'd2;

  function automatic logic signed [W40-1:0] sat40(input logic signed [ACC_W-1:0] x);
    if (x > S40_MAX) return S40_MAX[W40-1:0];
    else if (x < S40_MIN) return S40_MIN[W40-1:0];
    else return x[W40-1:0];
  endfunction

  // wrap a yaw difference into -180..180, keeping both ends
  function automatic logic signed [8:0] wrap_yaw(input logic signed [11:0] e);
    logic signed [11:0] w;
    if (e > 12'sd900)       w = e - 12'sd1080;
    else if (e > 12'sd540)  w = e - 12'sd720;
    else if (e > 12'sd180)  w = e - 12'sd360;
    else if (e < -12'sd900) w = e + 12'sd1080;
    else if (e < -12'sd540) w = e + 12'sd720;
    else if (e < -12'sd180) w = e + 12'sd360;
    else                    w = e;
    return w[8:0];
  endfunction

  // truncate toward zero, then keep the duty field bits
  function automatic logic signed [DUTY_W-1:0] to_duty(input logic signed [W40-1:0] x);
    logic signed [W40-1:0] s;
    s = x + (x[W40-1] ? RND : '0);
    s = s >>> FRAC_BITS;
    return s[DUTY_W-1:0];
  endfunction

  cfg_t cfg;

  cywp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer
  logic [3:0] state_r, state_nxt;
  logic [1:0] k_r, m_r;
  logic       out_valid_r;

  // captured request
  logic [1:0]         func_r;
  logic signed [15:0] base_r, lcnt_r, rcnt_r;
  logic signed [8:0]  yaw_r;

  // working registers
  logic signed [T_W-1:0]   t_r;
  logic signed [W40-1:0]   e0_r;
  logic signed [D_W-1:0]   d1_r, e12_r;
  logic signed [OP_W-1:0]  d2_r, op_r;
  logic signed [PP_W-1:0]  pp_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [DUTY_W-1:0] ldut_r, rdut_r;

  // PID history, index 0 heading, 1 left, 2 right
  logic signed [W40-1:0] last_err_r [NPID];
  logic signed [W40-1:0] old_err_r  [NPID];
  logic signed [W40-1:0] integ_r    [NPID];
  logic signed [W40-1:0] pout_r     [NPID];

  logic                    in_acc, mode;
  logic signed [W40-1:0]   e1, e2, isat, osat;
  logic signed [T_W-1:0]   base_s, h_s, t_nxt;
  logic signed [OP_W-1:0]  cnt_s, err_raw;
  logic signed [GAIN_W-1:0] gain;
  logic signed [HI_W-1:0]  op_hi;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PP_W-1:0]  prod;
  logic signed [11:0]      yaw_diff;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_acc         = in_valid & in_ready;
  assign out_valid      = out_valid_r;
  assign out_left_duty  = ldut_r;
  assign out_right_duty = rdut_r;

  assign e1   = last_err_r[k_r];
  assign e2   = old_err_r[k_r];
  assign mode = (k_r == PID_HEAD) ? cfg.heading_mode : cfg.wheel_mode;

  assign yaw_diff = 12'(in_target_yaw) - 12'(in_measured_yaw);

  assign base_s = T_W'(base_r) <<< FRAC_BITS;
  assign h_s    = (func_r == FUNC_TURN) ? T_W'(pout_r[PID_HEAD]) : '0;

  always_comb begin
    case (k_r)
      PID_HEAD: t_nxt = T_W'(yaw_r) <<< FRAC_BITS;
      PID_LEFT: t_nxt = base_s - h_s;
      default:  t_nxt = base_s + h_s;
    endcase
  end

  always_comb begin
    case (k_r)
      PID_LEFT:  cnt_s = OP_W'(lcnt_r) <<< FRAC_BITS;
      PID_RIGHT: cnt_s = OP_W'(rcnt_r) <<< FRAC_BITS;
      default:   cnt_s = '0;
    endcase
  end

  assign err_raw = OP_W'(t_r) - cnt_s;

  always_comb begin
    case (m_r)
      MUL_KI:  gain = (k_r == PID_HEAD) ? cfg.heading_ki : cfg.wheel_ki;
      MUL_KP:  gain = (k_r == PID_HEAD) ? cfg.heading_kp : cfg.wheel_kp;
      default: gain = (k_r == PID_HEAD) ? cfg.heading_kd : cfg.wheel_kd;
    endcase
  end

  // shared multiplier: gain times low (unsigned) or high (signed) operand chunk
  assign op_hi = op_r[OP_W-1:LO_W];
  assign mul_b = (state_r == ST_MHI) ? MB_W'(op_hi) : $signed({1'b0, op_r[LO_W-1:0]});
  assign prod  = gain * mul_b;

  assign isat = sat40(acc_r);

  always_comb begin
    if (k_r == PID_HEAD)    osat = sat40(acc_r);
    else if (acc_r > LIM)   osat = LIM[W40-1:0];
    else if (acc_r < NEG_LIM) osat = NEG_LIM[W40-1:0];
    else                    osat = acc_r[W40-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func inside {FUNC_TURN, FUNC_SPEED}) state_nxt = ST_TGT;
          else state_nxt = ST_FIN;
        end
      end
      ST_TGT:  state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_DIF1;
      ST_DIF1: state_nxt = ST_DIF2;
      ST_DIF2: state_nxt = ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_MADD;
      ST_MADD: begin
        if (m_r == MUL_KI) state_nxt = ST_SATI;
        else if (m_r == MUL_KP) state_nxt = ST_MLO;
        else state_nxt = ST_SATO;
      end
      ST_SATI: state_nxt = ST_MLO;
      ST_SATO: state_nxt = (k_r == PID_RIGHT) ? ST_FIN : ST_TGT;
      ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= PID_HEAD;
      m_r         <= MUL_KI;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        k_r <= (in_func == FUNC_TURN) ? PID_HEAD : PID_LEFT;
      end
      if (state_r == ST_DIF2) m_r <= MUL_KI;
      if (state_r == ST_SATI) m_r <= MUL_KP;
      if (state_r == ST_MADD && m_r == MUL_KP) m_r <= MUL_KD;
      if (state_r == ST_SATO && k_r != PID_RIGHT) k_r <= k_r + 2'd1;
      if (state_r == ST_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      base_r <= in_base_speed;
      lcnt_r <= in_left_count;
      rcnt_r <= in_right_count;
      yaw_r  <= wrap_yaw(yaw_diff);
    end
    case (state_r)
      ST_TGT: t_r <= t_nxt;
      ST_ERR: e0_r <= sat40(ACC_W'(err_raw));
      ST_DIF1: begin
        d1_r  <= D_W'(e0_r) - D_W'(e1);
        e12_r <= D_W'(e1) - D_W'(e2);
      end
      ST_DIF2: begin
        d2_r  <= OP_W'(d1_r) - OP_W'(e12_r);
        acc_r <= mode ? ACC_W'(integ_r[k_r]) : '0;
        op_r  <= OP_W'(e0_r);
      end
      ST_MLO: pp_r <= prod;
      ST_MHI: begin
        acc_r <= acc_r + (ACC_W'(pp_r) >>> FRAC_BITS);
        pp_r  <= prod;
      end
      ST_MADD: begin
        acc_r <= acc_r + (ACC_W'(pp_r) <<< (LO_W - FRAC_BITS));
        if (m_r == MUL_KP) op_r <= mode ? OP_W'(d1_r) : d2_r;
      end
      ST_SATI: begin
        acc_r <= ACC_W'(isat) + (mode ? '0 : ACC_W'(pout_r[k_r]));
        op_r  <= mode ? OP_W'(e0_r) : OP_W'(d1_r);
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          ldut_r <= to_duty(pout_r[PID_LEFT]);
          rdut_r <= to_duty(pout_r[PID_RIGHT]);
        end
      end
      default: ;
    endcase
  end

  // PID history
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_func == FUNC_CLEAR)) begin
      for (int i = 0; i < NPID; i++) begin
        last_err_r[i] <= '0;
        old_err_r[i]  <= '0;
        integ_r[i]    <= '0;
        pout_r[i]     <= '0;
      end
    end else begin
      if (state_r == ST_SATI) integ_r[k_r] <= isat;
      if (state_r == ST_SATO) begin
        pout_r[k_r]     <= osat;
        old_err_r[k_r]  <= e1;
        last_err_r[k_r] <= e0_r;
      end
    end
  end

endmodule

@@ src/cywp_checker.sv @@
// Port-level checker for cascaded_yaw_wheel_pid, bound to the top level.
// Depends on cywp_pkg for field widths.
module cywp_checker
  import cywp_pkg::*;
#(
  parameter int DUTY_MAX = 9999
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DUTY_W-1:0] out_left_duty,
  input logic signed [DUTY_W-1:0] out_right_duty
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_duty)
      && $stable(out_right_duty))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after request accept");

  // duties stay inside the motor limit
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DUTY_MAX > 16383)
      || ($signed(out_left_duty) <= DUTY_MAX && $signed(out_left_duty) >= -DUTY_MAX
       && $signed(out_right_duty) <= DUTY_MAX && $signed(out_right_duty) >= -DUTY_MAX))
    else $error("duty beyond limit");

  // drop any pending result on reset
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind cascaded_yaw_wheel_pid cywp_checker #(.DUTY_MAX(DUTY_MAX)) u_cywp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_left_duty  (out_left_duty),
  .out_right_duty (out_right_duty)
);

@@ sim/tb_cascaded_yaw_wheel_pid.sv @@
// Testbench for cascaded_yaw_wheel_pid: drives ticks and APB gain writes, predicts duties.
// A bit-accurate shadow of the three PIDs checks every result in order.
// Depends on cywp_pkg and the RTL top level only.
module tb_cascaded_yaw_wheel_pid;
  import cywp_pkg::*;

  localparam int DUTY_MAX = 9999;
  localparam int FRAC_BITS = 8;
  localparam longint SCALE = 64'sd1 <<< FRAC_BITS;
  localparam longint DUTY_LIM = longint'(DUTY_MAX) * SCALE;
  localparam longint RUN_LIMIT = 64'd24_000_000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] base_speed;
    logic signed [9:0]  target_yaw;
    logic signed [9:0]  measured_yaw;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } duty_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_func;
  logic signed [15:0] in_base_speed, in_left_count, in_right_count;
  logic signed [9:0] in_target_yaw, in_measured_yaw;
  logic out_valid, out_ready;
  logic signed [DUTY_W-1:0] out_left_duty, out_right_duty;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata, cfg_prdata;

  // Shadow state of the controller: index 0 heading, 1 left, 2 right
  cfg_t gains_now;
  longint err_last[NPID];
  longint err_older[NPID];
  longint isum[NPID];
  longint pid_out[NPID];

  duty_t duty_due[$];
  int fail_count = 0;
  int hold_left = 0;
  int sink_max_stall = 0;

  cascaded_yaw_wheel_pid #(
    .DUTY_MAX(DUTY_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_base_speed(in_base_speed),
    .in_target_yaw(in_target_yaw),
    .in_measured_yaw(in_measured_yaw),
    .in_left_count(in_left_count),
    .in_right_count(in_right_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left_duty(out_left_duty),
    .out_right_duty(out_right_duty),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic longint sat40(longint x);
    if (x > S40_MAX) return S40_MAX;
    if (x < S40_MIN) return S40_MIN;
    return x;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(longint x);
    longint q;
    q = (x >= 0) ? (x >>> FRAC_BITS) : -((-x) >>> FRAC_BITS);
    return q[DUTY_W-1:0];
  endfunction

  function automatic void clear_history();
    for (int k = 0; k < NPID; k++) begin
      err_last[k] = 0;
      err_older[k] = 0;
      isum[k] = 0;
      pid_out[k] = 0;
    end
  endfunction

  function automatic void pid_update(int k, longint err, logic mode,
                                     longint kp, longint ki, longint kd);
    longint e0, e1, e2, p, d;
    e0 = sat40(err);
    e1 = err_last[k];
    e2 = err_older[k];
    if (!mode) begin
      p = (kp * (e0 - e1)) >>> FRAC_BITS;
      isum[k] = sat40((ki * e0) >>> FRAC_BITS);
      d = (kd * (e0 - 2 * e1 + e2)) >>> FRAC_BITS;
      pid_out[k] = sat40(pid_out[k] + p + isum[k] + d);
    end else begin
      p = (kp * e0) >>> FRAC_BITS;
      isum[k] = sat40(isum[k] + ((ki * e0) >>> FRAC_BITS));
      d = (kd * (e0 - e1)) >>> FRAC_BITS;
      pid_out[k] = sat40(p + isum[k] + d);
    end
    err_older[k] = e1;
    err_last[k] = e0;
  endfunction

  function automatic void wheel_update(int k, longint target, logic signed [15:0] count);
    pid_update(k, target - longint'(count) * SCALE, gains_now.wheel_mode,
               longint'(gains_now.wheel_kp), longint'(gains_now.wheel_ki),
               longint'(gains_now.wheel_kd));
    if (pid_out[k] > DUTY_LIM) pid_out[k] = DUTY_LIM;
    if (pid_out[k] < -DUTY_LIM) pid_out[k] = -DUTY_LIM;
  endfunction

  function automatic longint wrap_deg(longint e);
    while (e > 180) e -= 360;
    while (e < -180) e += 360;
    return e;
  endfunction

  function automatic duty_t compute_duties(tick_t t);
    longint base, h;
    duty_t r;
    base = longint'(t.base_speed) * SCALE;
    case (t.func)
      FUNC_SPEED: begin
        wheel_update(1, base, t.left_count);
        wheel_update(2, base, t.right_count);
      end
      FUNC_TURN: begin
        pid_update(0, wrap_deg(longint'(t.target_yaw) - longint'(t.measured_yaw)) * SCALE,
                   gains_now.heading_mode, longint'(gains_now.heading_kp),
                   longint'(gains_now.heading_ki), longint'(gains_now.heading_kd));
        h = pid_out[0];
        wheel_update(1, base - h, t.left_count);
        wheel_update(2, base + h, t.right_count);
      end
      FUNC_CLEAR: clear_history();
      default: ;
    endcase
    r.left_duty = duty_of(pid_out[1]);
    r.right_duty = duty_of(pid_out[2]);
    return r;
  endfunction

  function automatic tick_t mk_tick(logic [1:0] func, int base, int tyaw, int myaw,
                                    int lcnt, int rcnt);
    tick_t t;
    t.func = func;
    t.base_speed = base[15:0];
    t.target_yaw = tyaw[9:0];
    t.measured_yaw = myaw[9:0];
    t.left_count = lcnt[15:0];
    t.right_count = rcnt[15:0];
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int pick, base;
    pick = $urandom_range(0, 99);
    if (pick < 47) t.func = FUNC_TURN;
    else if (pick < 85) t.func = FUNC_SPEED;
    else if (pick < 94) t.func = FUNC_SPARE;
    else t.func = FUNC_CLEAR;
    if ($urandom_range(0, 3) == 0) base = $urandom;
    else base = int'($urandom_range(0, 400)) - 200;
    t.base_speed = base[15:0];
    if ($urandom_range(0, 1) == 0) begin
      t.target_yaw = 10'($urandom);
      t.measured_yaw = 10'($urandom);
    end else begin
      t.target_yaw = 10'(int'($urandom_range(0, 720)) - 360);
      t.measured_yaw = 10'(int'($urandom_range(0, 720)) - 360);
    end
    // Keep counts near the target most of the time so duties stay off the clamp
    if ($urandom_range(0, 4) == 0) begin
      t.left_count = 16'($urandom);
      t.right_count = 16'($urandom);
    end else begin
      t.left_count = 16'(int'(t.base_speed) + int'($urandom_range(0, 40)) - 20);
      t.right_count = 16'(int'(t.base_speed) + int'($urandom_range(0, 40)) - 20);
    end
    return t;
  endfunction

  function automatic logic [15:0] extreme_gain();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain(int style);
    if (style == 0) return 16'(int'($urandom_range(0, 1024)) - 512);
    if (style == 1) return 16'($urandom);
    return extreme_gain();
  endfunction

  function automatic cfg_t random_cfg(int style);
    cfg_t c;
    c.heading_mode = 1'($urandom_range(0, 1));
    c.wheel_mode = 1'($urandom_range(0, 1));
    c.heading_kp = pick_gain(style);
    c.heading_ki = pick_gain(style);
    c.heading_kd = pick_gain(style);
    c.wheel_kp = pick_gain(style);
    c.wheel_ki = pick_gain(style);
    c.wheel_kd = pick_gain(style);
    return c;
  endfunction

  // Result checker: each accepted result against the oldest prediction
  always @(posedge clk) begin : check_duty
    duty_t want;
    if (rst_n && out_valid && out_ready) begin
      if (duty_due.size() == 0) begin
        $error("unexpected result: left_duty %0d right_duty %0d",
               out_left_duty, out_right_duty);
        fail_count++;
      end else begin
        want = duty_due.pop_front();
        if (out_left_duty !== want.left_duty) begin
          $error("left_duty expected %0d got %0d", $signed(want.left_duty), out_left_duty);
          fail_count++;
        end
        if (out_right_duty !== want.right_duty) begin
          $error("right_duty expected %0d got %0d", $signed(want.right_duty),
                 out_right_duty);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random ready/stall runs, plus a counted hold-off on request
  initial begin : sink
    int run_left;
    run_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (sink_max_stall == 0) begin
        out_ready = 1'b1;
      end else begin
        if (run_left == 0) begin
          if (out_ready) begin
            out_ready = 1'b0;
            run_left = $urandom_range(1, sink_max_stall);
          end else begin
            out_ready = 1'b1;
            run_left = $urandom_range(1, 30);
          end
        end
        run_left--;
      end
    end
  end

  task automatic send_tick(tick_t t);
    @(negedge clk);
    in_valid = 1'b1;
    in_func = t.func;
    in_base_speed = t.base_speed;
    in_target_yaw = t.target_yaw;
    in_measured_yaw = t.measured_yaw;
    in_left_count = t.left_count;
    in_right_count = t.right_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    duty_due.push_back(compute_duties(t));
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (duty_due.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    logic [DATA_W-1:0] wdata;
    // Upper data bits carry noise; only the register's own bits count
    wdata = $urandom;
    if (idx == REG_HEADING_MODE || idx == REG_WHEEL_MODE) wdata[0] = val[0];
    else wdata[GAIN_W-1:0] = val;
    @(negedge clk);
    in_valid = 1'b0;
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_HEADING_MODE: gains_now.heading_mode = val[0];
      REG_HEADING_KP:   gains_now.heading_kp = val;
      REG_HEADING_KI:   gains_now.heading_ki = val;
      REG_HEADING_KD:   gains_now.heading_kd = val;
      REG_WHEEL_MODE:   gains_now.wheel_mode = val[0];
      REG_WHEEL_KP:     gains_now.wheel_kp = val;
      REG_WHEEL_KI:     gains_now.wheel_ki = val;
      REG_WHEEL_KD:     gains_now.wheel_kd = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic load_cfg(cfg_t c);
    // Write gains only with the block idle
    wait_drained();
    repeat (4) @(negedge clk);
    reg_write(REG_HEADING_MODE, {15'd0, c.heading_mode});
    reg_write(REG_HEADING_KP, c.heading_kp);
    reg_write(REG_HEADING_KI, c.heading_ki);
    reg_write(REG_HEADING_KD, c.heading_kd);
    reg_write(REG_WHEEL_MODE, {15'd0, c.wheel_mode});
    reg_write(REG_WHEEL_KP, c.wheel_kp);
    reg_write(REG_WHEEL_KI, c.wheel_ki);
    reg_write(REG_WHEEL_KD, c.wheel_kd);
  endtask

  task automatic test_after_reset();
    // Zero gains after reset: every duty stays zero
    send_tick(mk_tick(FUNC_TURN, 1234, 90, -45, -17, 300));
    send_tick(mk_tick(FUNC_SPEED, -500, 0, 0, 12, -12));
    send_tick(mk_tick(FUNC_SPARE, 77, 5, 5, 5, 5));
  endtask

  task automatic test_directed();
    cfg_t c;
    c.heading_mode = 1'b0;
    c.heading_kp = 16'sd256;
    c.heading_ki = 16'sd64;
    c.heading_kd = 16'sd32;
    c.wheel_mode = 1'b1;
    c.wheel_kp = 16'sd128;
    c.wheel_ki = 16'sd32;
    c.wheel_kd = 16'sd16;
    load_cfg(c);
    send_tick(mk_tick(FUNC_TURN, 100, 180, 0, 0, 0));        // error exactly +180
    send_tick(mk_tick(FUNC_TURN, 100, 0, 180, 0, 0));        // error exactly -180
    send_tick(mk_tick(FUNC_TURN, 0, 511, -512, 3, -3));      // widest positive span
    send_tick(mk_tick(FUNC_TURN, 0, -512, 511, -3, 3));      // widest negative span
    send_tick(mk_tick(FUNC_TURN, 50, 360, -360, 50, 50));
    send_tick(mk_tick(FUNC_TURN, 0, 0, 181, 0, 0));          // wraps to +179
    send_tick(mk_tick(FUNC_SPEED, 32767, 0, 0, -32768, -32768));
    send_tick(mk_tick(FUNC_SPEED, -32768, 0, 0, 32767, 32767));
    send_tick(mk_tick(FUNC_SPARE, 0, 0, 0, 0, 0));           // read back stored outputs
    send_tick(mk_tick(FUNC_CLEAR, 999, 100, -100, 9, 9));
    send_tick(mk_tick(FUNC_SPARE, 1, 1, 1, 1, 1));
    c.heading_mode = 1'b1;
    c.heading_kp = 16'sh7FFF;
    c.heading_ki = 16'sh7FFF;
    c.heading_kd = 16'sh7FFF;
    c.wheel_mode = 1'b0;
    c.wheel_kp = 16'sh8000;
    c.wheel_ki = 16'sh8000;
    c.wheel_kd = 16'sh8000;
    load_cfg(c);
    send_tick(mk_tick(FUNC_TURN, 32767, 180, 0, -32768, 32767));
    send_tick(mk_tick(FUNC_TURN, -32768, 0, 180, 32767, -32768));
    send_tick(mk_tick(FUNC_TURN, 0, 180, 0, 0, 0));
    send_tick(mk_tick(FUNC_SPEED, 32767, 0, 0, 0, 0));
    send_tick(mk_tick(FUNC_SPEED, -1, 0, 0, 1, -1));
    send_tick(mk_tick(FUNC_SPARE, 0, -512, 511, 0, 0));
    send_tick(mk_tick(FUNC_CLEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic test_input_stall();
    load_cfg(random_cfg(0));
    sink_max_stall = 0;
    @(negedge clk);
    hold_left = 600;
    // Offer ticks back to back while the receiver holds off
    repeat (12) send_tick(random_tick());
    wait_drained();
    repeat (5) send_tick(random_tick());
    wait_drained();
  endtask

  task automatic test_random();
    cfg_t c;
    int n, burst, r;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          c.heading_mode = 1'b1;
          c.wheel_mode = 1'b0;
          c.heading_kp = 16'sh7FFF;
          c.heading_ki = 16'sh7FFF;
          c.heading_kd = 16'sh7FFF;
          c.wheel_kp = 16'sh7FFF;
          c.wheel_ki = 16'sh7FFF;
          c.wheel_kd = 16'sh7FFF;
        end
        1: begin
          c.heading_mode = 1'b0;
          c.wheel_mode = 1'b1;
          c.heading_kp = 16'sh8000;
          c.heading_ki = 16'sh8000;
          c.heading_kd = 16'sh8000;
          c.wheel_kp = 16'sh8000;
          c.wheel_ki = 16'sh8000;
          c.wheel_kd = 16'sh8000;
        end
        default: c = random_cfg(phase % 3);
      endcase
      load_cfg(c);
      sink_max_stall = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 4 : 20);
      n = 0;
      while (n < 170) begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_tick(random_tick());
        n += burst;
        r = $urandom_range(0, 9);
        if (r < 3) ;
        else if (r < 7) idle_input($urandom_range(1, 8));
        else if (r < 9) idle_input($urandom_range(9, 60));
        else wait_drained();
      end
    end
  endtask

  initial begin : main
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_SPEED;
    in_base_speed = '0;
    in_target_yaw = '0;
    in_measured_yaw = '0;
    in_left_count = '0;
    in_right_count = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    gains_now = '0;
    clear_history();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_after_reset();
    test_directed();
    test_input_stall();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_cascaded_yaw_wheel_pid: done, clean");
    end else begin
      $display("tb_cascaded_yaw_wheel_pid: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("tb_cascaded_yaw_wheel_pid: done, errors");
    $finish;
  end

endmodule

@@ cascaded_yaw_wheel_pid.f @@
src/cywp_pkg.sv
src/cywp_regs.sv
src/cascaded_yaw_wheel_pid.sv
src/cywp_checker.sv
sim/tb_cascaded_yaw_wheel_pid.sv
